[src/cra_pkg.sv]
// shared types, constants and offset arithmetic for the contiguous ring allocator
`timescale 1ns / 1ps

package cra_pkg;

	// ring size and derived widths
	localparam int unsigned DEPTH = 4096;
	localparam int OFF_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int AMT_W  = 13;
	localparam int CNT_W  = 12;
	localparam int ST_W   = 2;
	localparam int CALC_W = (OFF_W + 2 > AMT_W + 1) ? OFF_W + 2 : AMT_W + 1;

	typedef logic [OFF_W-1:0]  off_t;
	typedef logic [CALC_W-1:0] calc_t;
	typedef logic [AMT_W-1:0]  amount_t;
	typedef logic [CNT_W-1:0]  count_t;
	typedef logic [ST_W-1:0]   status_t;

	localparam calc_t DEPTH_C = CALC_W'(DEPTH);
	localparam calc_t ONE_C   = CALC_W'(1);

	// request codes
	localparam logic FN_ALLOC   = 1'b0;
	localparam logic FN_CONSUME = 1'b1;

	// status codes
	localparam status_t ST_OK           = 2'd0;
	localparam status_t ST_NO_SPACE     = 2'd1;
	localparam status_t ST_NO_FIT       = 2'd2;
	localparam status_t ST_OVER_CONSUME = 2'd3;

	// one result beat
	typedef struct packed {
		logic    ok;
		count_t  region_offset;
		status_t status;
		count_t  free_bytes;
		count_t  used_bytes;
	} cra_result_t;

	// free space, (tail - head - 1) mod depth
	function automatic calc_t free_of(input off_t h, input off_t t);
		calc_t hw;
		calc_t tw;
		hw = CALC_W'(h);
		tw = CALC_W'(t);
		if (tw > hw) begin
			return tw - hw - ONE_C;
		end
		return tw + DEPTH_C - hw - ONE_C;
	endfunction

	// used space, (head - tail) mod depth
	function automatic calc_t used_of(input off_t h, input off_t t);
		calc_t hw;
		calc_t tw;
		hw = CALC_W'(h);
		tw = CALC_W'(t);
		if (hw >= tw) begin
			return hw - tw;
		end
		return hw + DEPTH_C - tw;
	endfunction

	// narrow a count to the result field width
	function automatic count_t to_count(input calc_t v);
		return v[CNT_W-1:0];
	endfunction

endpackage

[src/cra_step_logic.sv]
// allocate / consume decision and next head and tail offsets
`timescale 1ns / 1ps

module cra_step_logic (
	input  cra_pkg::off_t        head,
	input  cra_pkg::off_t        tail,
	input  logic                 func,
	input  cra_pkg::amount_t     amount,
	output cra_pkg::off_t        head_next,
	output cra_pkg::off_t        tail_next,
	output cra_pkg::cra_result_t result
);
	import cra_pkg::*;

	calc_t hw;
	calc_t tw;
	calc_t nw;
	calc_t free_now;
	calc_t used_now;
	calc_t sum;
	calc_t region;
	logic  ok;
	status_t status;

	// decide the request against the current offsets
	always_comb begin
		hw        = CALC_W'(head);
		tw        = CALC_W'(tail);
		nw        = CALC_W'(amount);
		free_now  = free_of(head, tail);
		used_now  = used_of(head, tail);
		sum       = '0;
		head_next = head;
		tail_next = tail;
		ok        = 1'b0;
		region    = '0;
		status    = ST_OK;
		if (func == FN_ALLOC) begin
			sum = hw + nw;
			priority if (nw > free_now) begin
				status = ST_NO_SPACE;
			end else if (hw >= tw) begin
				priority if (nw <= DEPTH_C - hw) begin
					head_next = (sum == DEPTH_C) ? '0 : sum[OFF_W-1:0];
					region    = hw;
					ok        = 1'b1;
				end else if (tw > nw) begin
					// wrap the region to the start of the ring
					head_next = nw[OFF_W-1:0];
					ok        = 1'b1;
				end else begin
					status = ST_NO_FIT;
				end
			end else begin
				if (tw - hw - ONE_C >= nw) begin
					head_next = sum[OFF_W-1:0];
					region    = hw;
					ok        = 1'b1;
				end else begin
					status = ST_NO_FIT;
				end
			end
		end else begin
			sum = tw + nw;
			if (nw > used_now) begin
				status = ST_OVER_CONSUME;
			end else begin
				tail_next = (sum >= DEPTH_C) ? off_t'(sum - DEPTH_C) : sum[OFF_W-1:0];
				ok        = 1'b1;
			end
		end
	end

	// result fields from the updated offsets
	always_comb begin
		result.ok            = ok;
		result.region_offset = ok ? to_count(region) : '0;
		result.status        = status;
		result.free_bytes    = to_count(free_of(head_next, tail_next));
		result.used_bytes    = to_count(used_of(head_next, tail_next));
	end

endmodule

[src/contiguous_ring_allocator_top.sv]
// Contiguous ring allocator: tracks head and tail offsets over a byte ring.
// Request channel (req_valid/req_ready) carries func and amount: func 0
// allocates a contiguous region of amount bytes at the head (wrapping to
// offset 0 when it would run past the end), func 1 releases amount bytes at
// the tail. One byte of the ring always stays free.
// Response channel (rsp_valid/rsp_ready) returns one beat per request: ok,
// region_offset, status, and the free and used byte counts after the request.
// An accepted request is captured in the request register, decided from there,
// and its result is captured in the result register that drives the response
// channel; a beat waiting on rsp_ready can hold it in the request register.
// Throughput: one request per cycle while rsp_ready does not stall the result
// register; the limit is the combinational path from the request register
// through the offset compare and update into the result register.
// Reset: arst_n low clears head and tail to zero (empty ring) and drops all
// pending beats.
// Stall: with a beat waiting and rsp_ready low the result register holds; one
// more request can wait in the request register, then req_ready goes low.
`timescale 1ns / 1ps

module contiguous_ring_allocator_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  logic               func,
	input  cra_pkg::amount_t   amount,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output logic               ok,
	output cra_pkg::count_t    region_offset,
	output cra_pkg::status_t   status,
	output cra_pkg::count_t    free_bytes,
	output cra_pkg::count_t    used_bytes
);
	import cra_pkg::*;

	logic        valid_s1;
	logic        func_s1;
	amount_t     amount_s1;
	logic        valid_s2;
	cra_result_t result_s2;
	off_t        head_q;
	off_t        tail_q;
	off_t        head_next;
	off_t        tail_next;
	cra_result_t result_next;
	logic        advance;
	logic        fire_s1;

	// flow control
	assign advance   = !valid_s2 || rsp_ready;
	assign fire_s1   = valid_s1 && advance;
	assign req_ready = !valid_s1 || advance;

	// decision logic
	cra_step_logic u_step (
		.head      (head_q),
		.tail      (tail_q),
		.func      (func_s1),
		.amount    (amount_s1),
		.head_next (head_next),
		.tail_next (tail_next),
		.result    (result_next)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			head_q   <= '0;
			tail_q   <= '0;
		end else begin
			if (req_ready) begin
				valid_s1 <= req_valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
			if (fire_s1) begin
				head_q <= head_next;
				tail_q <= tail_next;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			func_s1   <= func;
			amount_s1 <= amount;
		end
		if (fire_s1) begin
			result_s2 <= result_next;
		end
	end

	// response beat
	assign rsp_valid     = valid_s2;
	assign ok            = result_s2.ok;
	assign region_offset = result_s2.region_offset;
	assign status        = result_s2.status;
	assign free_bytes    = result_s2.free_bytes;
	assign used_bytes    = result_s2.used_bytes;

	// offsets stay inside the ring
	a_offsets_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q <= off_t'(DEPTH - 1)) && (tail_q <= off_t'(DEPTH - 1)))
		else $error("head or tail offset outside the ring");

	// ok flag agrees with the status code
	a_ok_matches_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (ok == (status == ST_OK)))
		else $error("ok flag disagrees with status");

	// failed requests carry a zero offset
	a_fail_offset_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !ok) |-> (region_offset == '0))
		else $error("failed request reports a nonzero offset");

	// offsets move only when a request is decided
	a_state_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!fire_s1 |=> ($stable(head_q) && $stable(tail_q)))
		else $error("offsets changed without a decided request");

endmodule

[dv/contiguous_ring_allocator_top_test.sv]
// testbench for the contiguous ring allocator: directed corners and random traffic with idling
`timescale 1ns / 1ps

module contiguous_ring_allocator_top_test;
	import cra_pkg::*;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    req_valid;
	logic    req_ready;
	logic    func;
	amount_t amount;
	logic    rsp_valid;
	logic    rsp_ready;
	logic    ok;
	count_t  region_offset;
	status_t status;
	count_t  free_bytes;
	count_t  used_bytes;

	// ring offsets as the allocator should hold them
	int unsigned ring_head;
	int unsigned ring_tail;

	// expected response beats, oldest first
	cra_result_t pending_results[$];
	int unsigned fail_count = 0;

	// idling switches for the request and response sides
	bit src_idle  = 1'b0;
	bit sink_idle = 1'b0;

	contiguous_ring_allocator_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.func(func),
		.amount(amount),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.ok(ok),
		.region_offset(region_offset),
		.status(status),
		.free_bytes(free_bytes),
		.used_bytes(used_bytes)
	);

	always #2 clk = ~clk;

	// run limit
	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// mostly short gaps, a few long ones
	function automatic int unsigned idle_length();
		int unsigned k;
		k = $urandom_range(0, 19);
		if (k < 16) begin
			return $urandom_range(1, 3);
		end else if (k < 19) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 60);
	endfunction

	// free bytes for the current offsets
	function automatic int unsigned ring_room();
		return (ring_tail + 2 * DEPTH - ring_head - 1) % DEPTH;
	endfunction

	// used bytes for the current offsets
	function automatic int unsigned ring_fill();
		return (ring_head + DEPTH - ring_tail) % DEPTH;
	endfunction

	// keep an amount inside its legal range
	function automatic amount_t clip_amount(input int unsigned v);
		return (v > DEPTH) ? amount_t'(DEPTH) : amount_t'(v);
	endfunction

	// apply one request to the offsets and build the response it should give
	function automatic cra_result_t predict_request(input logic fn, input amount_t amt);
		cra_result_t r;
		int unsigned h;
		int unsigned t;
		int unsigned n;
		h = ring_head;
		t = ring_tail;
		n = amt;
		r = '0;
		r.status = ST_OK;
		if (fn == FN_ALLOC) begin
			if (n > ring_room()) begin
				r.status = ST_NO_SPACE;
			end else if (h >= t) begin
				// head at or past tail, also the empty ring
				if (n <= DEPTH - h) begin
					r.ok = 1'b1;
					r.region_offset = count_t'(h);
					ring_head = (h + n) % DEPTH;
				end else if (t > n) begin
					// wrap the region to offset zero
					r.ok = 1'b1;
					r.region_offset = '0;
					ring_head = n;
				end else begin
					r.status = ST_NO_FIT;
				end
			end else if (t - h - 1 >= n) begin
				r.ok = 1'b1;
				r.region_offset = count_t'(h);
				ring_head = (h + n) % DEPTH;
			end else begin
				r.status = ST_NO_FIT;
			end
		end else begin
			if (n > ring_fill()) begin
				r.status = ST_OVER_CONSUME;
			end else begin
				r.ok = 1'b1;
				ring_tail = (t + n) % DEPTH;
			end
		end
		r.free_bytes = count_t'(ring_room());
		r.used_bytes = count_t'(ring_fill());
		return r;
	endfunction

	// send one request beat and record its expected response
	task automatic send_request(input logic fn, input amount_t amt);
		int unsigned gap;
		gap = 0;
		if (src_idle && $urandom_range(0, 2) == 0) begin
			gap = idle_length();
		end
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		func      <= fn;
		amount    <= amt;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		pending_results.push_back(predict_request(fn, amt));
	endtask

	// response side backpressure
	initial begin : sink_driver
		int unsigned stall_left;
		stall_left = 0;
		rsp_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left != 0) begin
				rsp_ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_ready <= 1'b1;
				if (sink_idle && $urandom_range(0, 3) == 0) begin
					stall_left = idle_length();
				end
			end
		end
	end

	function automatic void check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			fail_count++;
		end
	endfunction

	// compare each response beat with the oldest expectation
	always @(posedge clk) begin : response_check
		cra_result_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t response beat with nothing expected", $time);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("ok", want.ok, ok);
				check_field("region_offset", want.region_offset, region_offset);
				check_field("status", want.status, status);
				check_field("free_bytes", want.free_bytes, free_bytes);
				check_field("used_bytes", want.used_bytes, used_bytes);
			end
		end
	end

	// corners walked from the empty ring after reset
	task automatic test_directed_corners();
		send_request(FN_ALLOC, 13'd0);      // zero allocation on empty ring
		send_request(FN_ALLOC, 13'd4096);   // too large
		send_request(FN_CONSUME, 13'd1);    // over-consume on empty ring
		send_request(FN_CONSUME, 13'd0);
		send_request(FN_ALLOC, 13'd4095);   // fill the ring
		send_request(FN_ALLOC, 13'd1);      // no space when full
		send_request(FN_CONSUME, 13'd4095); // empty again at the last offset
		send_request(FN_ALLOC, 13'd2);      // wrap to offset zero
		send_request(FN_ALLOC, 13'd4092);   // head behind tail, exact fit
		send_request(FN_CONSUME, 13'd4096); // over-consume, top bit set
		send_request(FN_CONSUME, 13'd3000);
		send_request(FN_ALLOC, 13'd2);      // fit up to the end, head wraps to zero
		send_request(FN_ALLOC, 13'd100);
		send_request(FN_CONSUME, 13'd1197); // empty ring in the middle
		send_request(FN_ALLOC, 13'd4000);   // empty ring with no contiguous fit
		send_request(FN_ALLOC, 13'd3996);   // exact fit to the end
		send_request(FN_ALLOC, 13'd50);
		send_request(FN_ALLOC, 13'd50);     // head behind tail, no space
		send_request(FN_CONSUME, 13'd8191); // all amount bits high
	endtask

	// random mix of well-formed requests, boundary amounts and noise
	task automatic run_random_traffic(input int unsigned items);
		int unsigned room;
		int unsigned fill;
		int unsigned k;
		logic fn;
		amount_t amt;
		for (int i = 0; i < items; i++) begin
			room = ring_room();
			fill = ring_fill();
			k = $urandom_range(0, 9);
			fn = ($urandom_range(0, 1) == 0) ? FN_ALLOC : FN_CONSUME;
			if (fn == FN_ALLOC) begin
				if (k < 5) begin
					amt = clip_amount($urandom_range(0, (room < 512) ? room : 512));
				end else if (k < 8) begin
					case ($urandom_range(0, 5))
						0: amt = clip_amount(room);
						1: amt = clip_amount(room + 1);
						2: amt = clip_amount(DEPTH - ring_head);
						3: amt = clip_amount(DEPTH - ring_head + 1);
						4: amt = clip_amount(ring_tail);
						default: amt = clip_amount(ring_tail + 1);
					endcase
				end else begin
					amt = clip_amount($urandom_range(0, DEPTH));
				end
			end else begin
				if (k < 7) begin
					amt = clip_amount($urandom_range(0, fill));
				end else if (k < 9) begin
					amt = clip_amount(fill + $urandom_range(0, 1));
				end else begin
					amt = clip_amount($urandom_range(0, DEPTH));
				end
			end
			send_request(fn, amt);
		end
	endtask

	task automatic test_back_to_back();
		src_idle  = 1'b0;
		sink_idle = 1'b0;
		run_random_traffic(300);
	endtask

	task automatic test_sender_gaps();
		src_idle  = 1'b1;
		sink_idle = 1'b0;
		run_random_traffic(380);
	endtask

	task automatic test_receiver_stalls();
		src_idle  = 1'b0;
		sink_idle = 1'b1;
		run_random_traffic(380);
	endtask

	task automatic test_mixed_idle();
		src_idle  = 1'b1;
		sink_idle = 1'b1;
		run_random_traffic(370);
	endtask

	// reset, tests in turn, drain and verdict
	initial begin
		arst_n    = 1'b0;
		req_valid = 1'b0;
		func      = FN_ALLOC;
		amount    = '0;
		ring_head = 0;
		ring_tail = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_corners();
		test_back_to_back();
		test_sender_gaps();
		test_receiver_stalls();
		test_mixed_idle();
		req_valid <= 1'b0;
		sink_idle = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

[sim.f]
src/cra_pkg.sv
src/cra_step_logic.sv
src/contiguous_ring_allocator_top.sv
dv/contiguous_ring_allocator_top_test.sv
